// ----- src/tlbff_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbff_pkg : shared types and constants of the FIFO-fill TLB
// Request and result beats, controller states and the command / status
// groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tlbff_pkg;

    localparam int DEF_TLB_ENTRIES  = 16;
    localparam int DEF_PAGE_BYTES   = 1024;
    localparam int DEF_ADDRESS_BITS = 32;

    localparam int FIELD_W = 32;
    localparam int SLOT_W  = 4;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_FILL   = 1'b1;

    typedef struct packed {
        logic               action;
        logic [FIELD_W-1:0] virtual_address;
        logic [FIELD_W-1:0] physical_address;
        logic [FIELD_W-1:0] request_date;
    } request_t;

    typedef struct packed {
        logic               hit;
        logic [FIELD_W-1:0] translated_address;
        logic [SLOT_W-1:0]  filled_slot;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_CHECK,
        ST_WRITE,
        ST_RESPOND
    } state_t;

    typedef struct packed {
        logic load;        // capture request, rewind scan
        logic take_free;   // victim is the first invalid entry
        logic step;        // evaluate current entry, advance scan
        logic take_hit;    // record translation of current entry
        logic write;       // install mapping into victim
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_fill;
        logic has_free;
        logic match;
        logic last;
    } dp_status_t;

endpackage

// ----- src/tlbff_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbff_ctrl : request sequencer
// Walks one request through dispatch, the entry scan, the fill write and
// the one-cycle result strobe.
// ----------------------------------------------------------------------------
module tlbff_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  tlbff_pkg::dp_status_t status,
    output tlbff_pkg::ctrl_cmd_t  cmd,
    output logic                  busy,
    output logic                  done
);

    tlbff_pkg::state_t state_reg;
    tlbff_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlbff_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            tlbff_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = tlbff_pkg::ST_DISPATCH;
                end
            end
            tlbff_pkg::ST_DISPATCH:
            begin
                if (status.is_fill && status.has_free)
                begin
                    cmd.take_free = 1'b1;
                    state_next    = tlbff_pkg::ST_WRITE;
                end
                else
                begin
                    state_next = tlbff_pkg::ST_READ;
                end
            end
            tlbff_pkg::ST_READ:
            begin
                // memory read of the scan entry lands this cycle
                state_next = tlbff_pkg::ST_CHECK;
            end
            tlbff_pkg::ST_CHECK:
            begin
                priority if (!status.is_fill && status.match)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = tlbff_pkg::ST_RESPOND;
                end
                else if (status.last)
                begin
                    cmd.step   = 1'b1;
                    state_next = status.is_fill ? tlbff_pkg::ST_WRITE
                                                : tlbff_pkg::ST_RESPOND;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = tlbff_pkg::ST_READ;
                end
            end
            tlbff_pkg::ST_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = tlbff_pkg::ST_RESPOND;
            end
            tlbff_pkg::ST_RESPOND:
            begin
                done       = 1'b1;
                state_next = tlbff_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tlbff_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/tlbff_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbff_datapath : TLB entry store and scan datapath
// Holds valid bits, page / frame / date memories, the scan pointer, the
// oldest-entry tracker and the result registers.
// ----------------------------------------------------------------------------
module tlbff_datapath
#(
    parameter int TLB_ENTRIES  = tlbff_pkg::DEF_TLB_ENTRIES,
    parameter int PAGE_BYTES   = tlbff_pkg::DEF_PAGE_BYTES,
    parameter int ADDRESS_BITS = tlbff_pkg::DEF_ADDRESS_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tlbff_pkg::request_t   request,
    input  tlbff_pkg::ctrl_cmd_t  cmd,
    output tlbff_pkg::dp_status_t status,
    output tlbff_pkg::result_t    result
);

    localparam int ADDR_W = (ADDRESS_BITS < tlbff_pkg::FIELD_W) ? ADDRESS_BITS
                                                                 : tlbff_pkg::FIELD_W;
    localparam int OFS_W  = $clog2(PAGE_BYTES);
    localparam int TAG_W  = ADDR_W - OFS_W;
    localparam int IDX_W  = $clog2(TLB_ENTRIES);
    localparam int DATE_W = tlbff_pkg::FIELD_W;

    tlbff_pkg::request_t           req_reg;
    logic [TLB_ENTRIES-1:0]        valid_reg;
    logic [IDX_W-1:0]              scan_idx_reg;
    logic [IDX_W-1:0]              victim_reg;
    logic [DATE_W-1:0]             best_date_reg;
    logic                          hit_reg;
    logic [tlbff_pkg::FIELD_W-1:0] trans_reg;
    logic [tlbff_pkg::SLOT_W-1:0]  slot_reg;

    logic [TAG_W-1:0]              page_mem  [TLB_ENTRIES];
    logic [TAG_W-1:0]              frame_mem [TLB_ENTRIES];
    logic [DATE_W-1:0]             date_mem  [TLB_ENTRIES];
    logic [TAG_W-1:0]              rd_page_reg;
    logic [TAG_W-1:0]              rd_frame_reg;
    logic [DATE_W-1:0]             rd_date_reg;

    logic [TAG_W-1:0]              req_page;
    logic [TAG_W-1:0]              req_frame;
    logic [OFS_W-1:0]              req_offset;
    logic [IDX_W-1:0]              free_idx;
    logic                          has_free;

    assign req_page   = req_reg.virtual_address[ADDR_W-1:OFS_W];
    assign req_frame  = req_reg.physical_address[ADDR_W-1:OFS_W];
    assign req_offset = req_reg.virtual_address[OFS_W-1:0];

    // lowest invalid entry
    always_comb
    begin
        free_idx = '0;
        has_free = 1'b0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
                has_free = 1'b1;
            end
        end
    end

    assign status.is_fill  = (req_reg.action == tlbff_pkg::ACT_FILL);
    assign status.has_free = has_free;
    assign status.match    = valid_reg[scan_idx_reg] && (rd_page_reg == req_page);
    assign status.last     = (scan_idx_reg == IDX_W'(TLB_ENTRIES - 1));

    assign result.hit                = hit_reg;
    assign result.translated_address = trans_reg;
    assign result.filled_slot        = slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.write)
        begin
            valid_reg[victim_reg] <= 1'b1;
        end
    end

    // entry memories: one write port, one registered read at the scan pointer
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            page_mem[victim_reg]  <= req_page;
            frame_mem[victim_reg] <= req_frame;
            date_mem[victim_reg]  <= req_reg.request_date;
        end
        rd_page_reg  <= page_mem[scan_idx_reg];
        rd_frame_reg <= frame_mem[scan_idx_reg];
        rd_date_reg  <= date_mem[scan_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg      <= request;
            scan_idx_reg <= '0;
            hit_reg      <= 1'b0;
            trans_reg    <= '0;
            slot_reg     <= '0;
        end
        if (cmd.take_free)
        begin
            victim_reg <= free_idx;
        end
        if (cmd.step)
        begin
            // strict compare keeps the lowest index on a tie
            if (status.is_fill &&
                ((scan_idx_reg == '0) || (rd_date_reg < best_date_reg)))
            begin
                victim_reg    <= scan_idx_reg;
                best_date_reg <= rd_date_reg;
            end
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        if (cmd.take_hit)
        begin
            hit_reg   <= 1'b1;
            trans_reg <= tlbff_pkg::FIELD_W'({rd_frame_reg, req_offset});
        end
        if (cmd.write)
        begin
            slot_reg <= tlbff_pkg::SLOT_W'(victim_reg);
        end
    end

endmodule

// ----- src/tlb_lookup_fifo_fill.sv -----
`timescale 1ns / 1ps
// A lookup scans the entries from index 0 and stops at the first hit, a miss scans
// all TLB_ENTRIES; a fill into a free entry skips the scan, a fill into a full
// TLB scans all entries. The scan reads one entry at a time through the
// single read port of the entry memories. One request at a time: busy is high
// from the accepting edge until the done cycle ends; the receiver cannot stall.
// Reset clears all valid bits at once; no clearing pass is run.
// ----------------------------------------------------------------------------
// tlb_lookup_fifo_fill : fully associative TLB with oldest-first fill
// Lookups translate a virtual address; fills install a mapping into the
// first free entry or the entry with the oldest creation date.
// ----------------------------------------------------------------------------
module tlb_lookup_fifo_fill
#(
    parameter int TLB_ENTRIES  = tlbff_pkg::DEF_TLB_ENTRIES,
    parameter int PAGE_BYTES   = tlbff_pkg::DEF_PAGE_BYTES,
    parameter int ADDRESS_BITS = tlbff_pkg::DEF_ADDRESS_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tlbff_pkg::request_t request,
    output logic                done,
    output tlbff_pkg::result_t  result
);

    tlbff_pkg::ctrl_cmd_t  cmd;
    tlbff_pkg::dp_status_t status;

    tlbff_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tlbff_datapath
    #(
        .TLB_ENTRIES  (TLB_ENTRIES),
        .PAGE_BYTES   (PAGE_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    )
    u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

endmodule
